// File: rtl/ppm_p6_stream_parser_macros.svh
// Assertion macros for the P6 stream parser
`ifndef PPM_P6_STREAM_PARSER_MACROS_SVH
`define PPM_P6_STREAM_PARSER_MACROS_SVH
`ifndef SYNTH
`define PPM_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");
`define PPM_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define PPM_ASSERT_IMPL(lbl, clk, rstn, ante, cons)
`define PPM_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

// File: rtl/ppm_pkg.sv
`timescale 1ns / 1ps
package ppm_pkg;

  typedef enum logic [2:0] {
    PH_MAGIC_P    = 3'd0,
    PH_MAGIC_6    = 3'd1,
    PH_MAGIC_TAIL = 3'd2,
    PH_WIDTH      = 3'd3,
    PH_HEIGHT     = 3'd4,
    PH_MAXVAL     = 3'd5,
    PH_PIXELS     = 3'd6,
    PH_DONE       = 3'd7
  } phase_e;

  typedef enum logic [1:0] {
    KIND_HEADER = 2'd0,
    KIND_PIXEL  = 2'd1,
    KIND_ERROR  = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    ERR_MAGIC   = 3'd0,
    ERR_MISSING = 3'd1,
    ERR_WIDTH   = 3'd2,
    ERR_HEIGHT  = 3'd3,
    ERR_MAXVAL  = 3'd4,
    ERR_TRUNC   = 3'd5
  } err_e;

  // byte class, worked out by the front end
  typedef enum logic [2:0] {
    CLS_OTHER = 3'd0,
    CLS_SPACE = 3'd1,
    CLS_HASH  = 3'd2,
    CLS_DIGIT = 3'd3,
    CLS_EOL   = 3'd4
  } cls_e;

  localparam logic [7:0] CH_P    = 8'h50;
  localparam logic [7:0] CH_SIX  = 8'h36;
  localparam logic [7:0] CH_HASH = 8'h23;
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_LF   = 8'h0a;
  localparam logic [7:0] CH_CR   = 8'h0d;
  localparam logic [15:0] MAXVAL_OK = 16'd255;

  typedef struct packed {
    logic [7:0] data;
    logic       eoi;
    cls_e       cls;
    logic       is_p;
    logic       is_six;
  } tok_t;

  typedef struct packed {
    kind_e       kind;
    logic [23:0] pixel;
    logic [15:0] width;
    logic [15:0] height;
    err_e        err;
    logic        last;
  } res_t;

endpackage

// File: rtl/ppm_p6_stream_parser.sv
`timescale 1ns / 1ps
// Channel  | Dir | Handshake                  | Payload
// input    | in  | valid_i / stall_o          | data_byte_i, end_of_input_i
// result   | out | valid_o / stall_i          | result_kind_o .. last_pixel_o
// config   | in  | channel_order_we_i         | channel_order_i
// One byte per clock while results do not stall; byte and result are each registered.
// Front register classifies the byte, back end runs the parse state and
// one decimal multiply-add per digit byte on the width/height/maxval accumulator.
// Reset clears the parse state and channel order; no clearing pass.
// A stall on the result side holds the back end and, through it, the front register.
`include "ppm_p6_stream_parser_macros.svh"
module ppm_p6_stream_parser
  import ppm_pkg::*;
#(
  parameter int DIM_BITS    = 16,
  parameter int TOKEN_LIMIT = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  output logic        stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        end_of_input_i,
  input  logic        channel_order_we_i,
  input  logic        channel_order_i,
  output logic        valid_o,
  input  logic        stall_i,
  output logic [1:0]  result_kind_o,
  output logic [23:0] pixel_value_o,
  output logic [15:0] image_width_o,
  output logic [15:0] image_height_o,
  output logic [2:0]  error_code_o,
  output logic        last_pixel_o
);

  logic order_q;
  logic tok_valid, tok_stall;
  tok_t tok;
  res_t res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      order_q <= 1'b0;
    end else if (channel_order_we_i) begin
      order_q <= channel_order_i;
    end
  end

  ppm_front u_front (
    .clk_i, .rst_ni, .valid_i, .stall_o, .data_byte_i, .end_of_input_i,
    .tok_valid_o(tok_valid), .tok_stall_i(tok_stall), .tok_o(tok)
  );

  ppm_back #(.DIM_BITS(DIM_BITS), .TOKEN_LIMIT(TOKEN_LIMIT)) u_back (
    .clk_i, .rst_ni, .channel_order_i(order_q),
    .tok_valid_i(tok_valid), .tok_stall_o(tok_stall), .tok_i(tok),
    .res_valid_o(valid_o), .res_stall_i(stall_i), .res_o(res)
  );

  assign result_kind_o  = res.kind;
  assign pixel_value_o  = res.pixel;
  assign image_width_o  = res.width;
  assign image_height_o = res.height;
  assign error_code_o   = res.err;
  assign last_pixel_o   = res.last;

  `PPM_ASSERT_NEXT(a_hold, clk_i, rst_ni, valid_o && stall_i, valid_o && $stable(res))
  `PPM_ASSERT_IMPL(a_last_pix, clk_i, rst_ni, valid_o && res.last, res.kind == KIND_PIXEL)
  `PPM_ASSERT_IMPL(a_stall_chain, clk_i, rst_ni, tok_stall, valid_o && stall_i)

endmodule

// File: rtl/ppm_front.sv
`timescale 1ns / 1ps
module ppm_front
  import ppm_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       valid_i,
  output logic       stall_o,
  input  logic [7:0] data_byte_i,
  input  logic       end_of_input_i,
  output logic       tok_valid_o,
  input  logic       tok_stall_i,
  output tok_t       tok_o
);

  tok_t tok_q, tok_d;
  logic vld_q;
  cls_e cls;

  always_comb begin
    cls = CLS_OTHER;
    if (data_byte_i == CH_LF || data_byte_i == CH_CR) cls = CLS_EOL;
    else if (data_byte_i == 8'd32 || (data_byte_i >= 8'd9 && data_byte_i <= 8'd13))
      cls = CLS_SPACE;
    else if (data_byte_i == CH_HASH) cls = CLS_HASH;
    else if (data_byte_i >= CH_ZERO && data_byte_i <= 8'h39) cls = CLS_DIGIT;
    tok_d.data   = data_byte_i;
    tok_d.eoi    = end_of_input_i;
    tok_d.cls    = cls;
    tok_d.is_p   = (data_byte_i == CH_P);
    tok_d.is_six = (data_byte_i == CH_SIX);
  end

  assign stall_o     = vld_q && tok_stall_i;
  assign tok_valid_o = vld_q;
  assign tok_o       = tok_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (!stall_o) begin
      vld_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!stall_o && valid_i) begin
      tok_q <= tok_d;
    end
  end

endmodule

// File: rtl/ppm_back.sv
`timescale 1ns / 1ps
module ppm_back
  import ppm_pkg::*;
#(
  parameter int DIM_BITS    = 16,
  parameter int TOKEN_LIMIT = 64
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic channel_order_i,
  input  logic tok_valid_i,
  output logic tok_stall_o,
  input  tok_t tok_i,
  output logic res_valid_o,
  input  logic res_stall_i,
  output res_t res_o
);

  localparam int LW = $clog2(TOKEN_LIMIT);
  localparam logic [DIM_BITS-1:0] DIM_MAX = {DIM_BITS{1'b1}};
  localparam logic [LW-1:0] LEN_CAP = LW'(TOKEN_LIMIT - 1);

  phase_e              ph_q, ph_d;
  logic [DIM_BITS-1:0] acc_q, acc_d, w_q, w_d, h_q, h_d, col_q, col_d, row_q, row_d;
  logic [LW-1:0]       len_q, len_d;
  logic                cmt_q, cmt_d;
  logic [1:0]          dst_q, dst_d;
  logic [1:0]          chn_q, chn_d;
  logic [15:0]         held_q, held_d;
  logic                ovld_q;
  res_t                res_q, res_d;
  logic                emit;
  logic                take;
  logic [DIM_BITS+3:0] prod;
  logic [DIM_BITS-1:0] fin_acc;
  logic [1:0]          fin_dst;

  assign tok_stall_o = ovld_q && res_stall_i;
  assign take        = tok_valid_i && !tok_stall_o;
  assign res_valid_o = ovld_q;
  assign res_o       = res_q;
  assign prod = {4'd0, acc_q} * (DIM_BITS+4)'(10)
              + (DIM_BITS+4)'(tok_i.data - CH_ZERO);

  always_comb begin
    ph_d = ph_q; acc_d = acc_q; w_d = w_q; h_d = h_q; col_d = col_q; row_d = row_q;
    len_d = len_q; cmt_d = cmt_q; dst_d = dst_q; chn_d = chn_q; held_d = held_q;
    emit = 1'b0;
    res_d = '{kind: KIND_ERROR, pixel: 24'd0, width: 16'd0, height: 16'd0,
              err: ERR_MAGIC, last: 1'b0};
    fin_acc = acc_q;
    fin_dst = dst_q;
    if (tok_i.eoi) begin
      emit = 1'b1;
      unique case (ph_q)
        PH_MAGIC_P, PH_MAGIC_6: res_d.err = ERR_MAGIC;
        PH_MAGIC_TAIL:          res_d.err = ERR_MISSING;
        PH_WIDTH, PH_HEIGHT, PH_MAXVAL: begin
          if (len_q == '0) res_d.err = ERR_MISSING;
          else if (!dst_q[0]) res_d.err = err_e'(ph_q - PH_WIDTH + 3'd2);
          else if (ph_q == PH_MAXVAL && acc_q != DIM_BITS'(MAXVAL_OK))
            res_d.err = ERR_MAXVAL;
          else if (ph_q == PH_MAXVAL) res_d.err = ERR_TRUNC;
          else res_d.err = ERR_MISSING;
        end
        PH_PIXELS: res_d.err = ERR_TRUNC;
        default:   emit = 1'b0;
      endcase
      ph_d = PH_MAGIC_P; acc_d = '0; len_d = '0; dst_d = '0; cmt_d = 1'b0;
      w_d = '0; h_d = '0; chn_d = '0; held_d = '0; col_d = '0; row_d = '0;
    end else begin
      unique case (ph_q)
        PH_MAGIC_P: if (!tok_i.is_p) begin emit = 1'b1; ph_d = PH_DONE; end
          else ph_d = PH_MAGIC_6;
        PH_MAGIC_6: if (!tok_i.is_six) begin emit = 1'b1; ph_d = PH_DONE; end
          else ph_d = PH_MAGIC_TAIL;
        PH_MAGIC_TAIL: begin
          if (tok_i.cls == CLS_SPACE || tok_i.cls == CLS_EOL || tok_i.cls == CLS_HASH) begin
            ph_d = PH_WIDTH; acc_d = '0; len_d = '0; dst_d = '0;
            cmt_d = (tok_i.cls == CLS_HASH);
          end
        end
        PH_WIDTH, PH_HEIGHT, PH_MAXVAL: begin
          if (cmt_q) begin
            if (tok_i.cls == CLS_EOL) cmt_d = 1'b0;
          end else if (len_q == '0 && (tok_i.cls == CLS_SPACE || tok_i.cls == CLS_EOL)) begin
          end else if (len_q == '0 && tok_i.cls == CLS_HASH) begin
            cmt_d = 1'b1;
          end else if (len_q != '0 && (tok_i.cls == CLS_SPACE || tok_i.cls == CLS_EOL
                       || (tok_i.cls == CLS_HASH && ph_q != PH_MAXVAL))) begin
            // token ends
            acc_d = '0; len_d = '0; dst_d = '0;
            if (tok_i.cls == CLS_HASH) cmt_d = 1'b1;
            if (!dst_q[0]) begin
              emit = 1'b1; ph_d = PH_DONE;
              res_d.err = err_e'(ph_q - PH_WIDTH + 3'd2);
            end else if (ph_q == PH_WIDTH) begin
              w_d = acc_q; ph_d = PH_HEIGHT;
            end else if (ph_q == PH_HEIGHT) begin
              h_d = acc_q; ph_d = PH_MAXVAL;
            end else if (acc_q != DIM_BITS'(MAXVAL_OK)) begin
              emit = 1'b1; ph_d = PH_DONE; res_d.err = ERR_MAXVAL;
            end else begin
              emit = 1'b1;
              res_d.kind = KIND_HEADER; res_d.err = ERR_MAGIC;
              res_d.width = 16'(w_q); res_d.height = 16'(h_q);
              chn_d = '0; held_d = '0; col_d = '0; row_d = '0;
              ph_d = (w_q == '0 || h_q == '0) ? PH_DONE : PH_PIXELS;
            end
          end else if (len_q < LEN_CAP) begin
            len_d = len_q + 1'b1;
            if (tok_i.cls == CLS_DIGIT) begin
              fin_dst = (len_q == '0) ? 2'b11 : dst_q;
              dst_d = fin_dst;
              if (fin_dst[1]) begin
                fin_acc = (prod > (DIM_BITS+4)'(DIM_MAX)) ? DIM_MAX : prod[DIM_BITS-1:0];
                acc_d = fin_acc;
              end
            end else begin
              dst_d = {1'b0, dst_q[0]};
            end
          end
        end
        PH_PIXELS: begin
          if (chn_q == 2'd0) begin
            held_d = {tok_i.data, 8'd0}; chn_d = 2'd1;
          end else if (chn_q == 2'd1) begin
            held_d = {held_q[15:8], tok_i.data}; chn_d = 2'd2;
          end else begin
            emit = 1'b1;
            res_d.kind = KIND_PIXEL; res_d.err = ERR_MAGIC;
            res_d.pixel = channel_order_i ? {tok_i.data, held_q[7:0], held_q[15:8]}
                                          : {held_q, tok_i.data};
            res_d.last = (col_q + 1'b1 == w_q) && (row_q + 1'b1 == h_q);
            chn_d = 2'd0;
            if (col_q + 1'b1 >= w_q) begin
              col_d = '0; row_d = row_q + 1'b1;
            end else begin
              col_d = col_q + 1'b1;
            end
            if (res_d.last) ph_d = PH_DONE;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q <= PH_MAGIC_P; acc_q <= '0; w_q <= '0; h_q <= '0; col_q <= '0; row_q <= '0;
      len_q <= '0; cmt_q <= 1'b0; dst_q <= '0; chn_q <= '0; held_q <= '0;
      ovld_q <= 1'b0;
    end else begin
      if (take) begin
        ph_q <= ph_d; acc_q <= acc_d; w_q <= w_d; h_q <= h_d; col_q <= col_d;
        row_q <= row_d; len_q <= len_d; cmt_q <= cmt_d; dst_q <= dst_d;
        chn_q <= chn_d; held_q <= held_d;
      end
      if (!tok_stall_o) ovld_q <= take && emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && emit && !tok_stall_o) res_q <= res_d;
  end

endmodule
